// File: rtl/ipv4ov_pkg.sv
package ipv4ov_pkg;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_SEC  = 3'd0,
        KIND_LSRR = 3'd1,
        KIND_SSRR = 3'd2,
        KIND_RR   = 3'd3,
        KIND_TS   = 3'd4
    } kind_t;

    localparam int unsigned NUM_KINDS = 5;

    localparam logic [7:0] OPT_EOL  = 8'h00;
    localparam logic [7:0] OPT_NOP  = 8'h01;
    localparam logic [7:0] OPT_RR   = 8'h07;
    localparam logic [7:0] OPT_SEC  = 8'h82;
    localparam logic [7:0] OPT_LSRR = 8'h83;
    localparam logic [7:0] OPT_TS   = 8'h88;
    localparam logic [7:0] OPT_SSRR = 8'h89;

    localparam logic [7:0] SEC_LEN    = 8'd11;
    localparam logic [7:0] TS_LEN     = 8'd4;
    localparam logic [7:0] ROUTE_MIN  = 8'd3;
    localparam logic [7:0] HDR_BYTES  = 8'd2;

    localparam logic [7:0] TS_FLG_ONLY = 8'd0;
    localparam logic [7:0] TS_FLG_ADDR = 8'd1;
    localparam logic [7:0] TS_FLG_PRES = 8'd3;

endpackage

// File: rtl/ipv4_option_validator.sv
// the verdict is registered at m_ after the final byte leaves the input register
// throughput: one option byte per cycle, limited only by the input register
// and the parser state update; stalls only when a verdict is held at m_
// reset: aresetn is synchronous and active low; it empties both registers
// and returns the parser to expecting an option type with nothing seen
module ipv4_option_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_option_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_verdict
);
    import ipv4ov_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    logic       verdict_reg;
    logic       verdict_comb;
    logic       advance;

    // bytes that give no verdict never wait on the result side
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_option_byte;
            in_last_reg <= s_last_byte;
        end
        if (advance && in_last_reg) begin
            verdict_reg <= verdict_comb;
        end
    end

    ipv4ov_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .option_byte (in_byte_reg),
        .last_byte   (in_last_reg),
        .verdict     (verdict_comb)
    );

    assign m_valid   = out_valid_reg;
    assign m_verdict = verdict_reg;

endmodule

// File: rtl/ipv4ov_parser.sv
module ipv4ov_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] option_byte,
    input  logic       last_byte,
    output logic       verdict
);
    import ipv4ov_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [NUM_KINDS-1:0]   seen_reg, seen_next;
    logic [7:0]             left_reg, left_next;
    logic [1:0]             pos_reg, pos_next;
    kind_t                  kind_reg, kind_next;
    logic                   err_reg, err_next;
    logic                   known;
    kind_t                  kind_dec;
    logic                   len_ok;
    logic [7:0]             left_dec;

    always_comb begin
        known    = 1'b1;
        kind_dec = KIND_SEC;
        case (option_byte)
            OPT_SEC:  kind_dec = KIND_SEC;
            OPT_LSRR: kind_dec = KIND_LSRR;
            OPT_SSRR: kind_dec = KIND_SSRR;
            OPT_RR:   kind_dec = KIND_RR;
            OPT_TS:   kind_dec = KIND_TS;
            default:  known = 1'b0;
        endcase
    end

    always_comb begin
        case (kind_reg)
            KIND_SEC: len_ok = (option_byte == SEC_LEN);
            KIND_TS:  len_ok = (option_byte == TS_LEN);
            default:  len_ok = (option_byte >= ROUTE_MIN);
        endcase
    end

    assign left_dec = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;

    always_comb begin
        phase_next = phase_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        err_next   = err_reg;
        case (phase_reg)
            PH_TYPE: begin
                if (option_byte == OPT_EOL) begin
                    phase_next = PH_DONE;
                end else if (option_byte == OPT_NOP) begin
                    phase_next = PH_TYPE;
                end else if (!known || seen_reg[kind_dec]) begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    seen_next[kind_dec] = 1'b1;
                    kind_next  = kind_dec;
                    pos_next   = 2'd1;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (!len_ok) begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    left_next  = option_byte - HDR_BYTES;
                    pos_next   = 2'd2;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                // timestamp flag byte is the fourth byte of the option
                if (kind_reg == KIND_TS && pos_reg == 2'd3 &&
                    option_byte != TS_FLG_ONLY && option_byte != TS_FLG_ADDR &&
                    option_byte != TS_FLG_PRES) begin
                    err_next   = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    if (pos_reg != 2'd3) begin
                        pos_next = pos_reg + 2'd1;
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_TYPE;
                        pos_next   = 2'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // an option still open at the final byte ran past the end
    assign verdict = err_next || phase_next == PH_LEN || phase_next == PH_BODY;

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_byte)) begin
            phase_reg <= PH_TYPE;
            seen_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            kind_reg  <= KIND_SEC;
            err_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            seen_reg  <= seen_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
        end
    end

endmodule
